@@ src/igr_pkg.sv @@
// Shared types and constants of the isometric grid edge rasterizer.
package igr_pkg;

   // Input and configuration widths.
   localparam int IDX_W       = 6;
   localparam int HGT_W       = 3;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int COORD_W     = 12;
   localparam int PITCH_W     = 14;
   localparam int BPP_W       = 3;
   localparam int COLOR_W     = 32;
   localparam int OFF_W       = 26;

   // Internal widths.
   localparam int X_W         = 10;  // projected x of the start point
   localparam int Y_W         = 10;  // projected y of the start point, signed
   localparam int DY_W        = 7;   // vertical rise of an edge, signed
   localparam int LEN_W       = 6;   // steps along the major axis
   localparam int Q_W         = 3;   // quotient along the minor axis
   localparam int PX_W        = 13;  // screen x
   localparam int PY_W        = 14;  // screen y, signed
   localparam int PRODY_W     = COORD_W + PITCH_W;
   localparam int PRODX_W     = COORD_W + BPP_W;

   // Projection constants.
   localparam int GRID_DX     = 7;
   localparam int GRID_DY     = 4;
   localparam int HEIGHT_DY   = 8;
   localparam int LEVEL_LEN   = 7;
   localparam int LEVEL_NUM   = 4;
   localparam int SLOPE_NUM   = 7;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_ORIGIN_X        = 3'd0,
      REG_ORIGIN_Y        = 3'd1,
      REG_ROW_PITCH       = 3'd2,
      REG_BYTES_PER_PIXEL = 3'd3,
      REG_CANVAS_WIDTH    = 3'd4,
      REG_CANVAS_HEIGHT   = 3'd5,
      REG_PIXEL_COLOR     = 3'd6
   } csr_reg_type;

   typedef struct packed {
      logic [COORD_W-1:0] origin_x;
      logic [COORD_W-1:0] origin_y;
      logic [PITCH_W-1:0] row_pitch;
      logic [BPP_W-1:0]   bytes_per_pixel;
      logic [COORD_W-1:0] canvas_width;
      logic [COORD_W-1:0] canvas_height;
      logic [COLOR_W-1:0] pixel_color;
   } cfg_type;

   // One classified edge waiting for the stepper.
   typedef struct packed {
      logic [X_W-1:0]        x;
      logic signed [Y_W-1:0] y;
      logic                  level;
      logic                  dy_neg;
      logic [LEN_W-1:0]      len;
      logic [Q_W-1:0]        num;
   } job_type;

   // One screen position produced by the stepper.
   typedef struct packed {
      logic [PX_W-1:0]        px;
      logic signed [PY_W-1:0] py;
      logic                   last;
   } pix_type;

endpackage

@@ src/igr_if.sv @@
// Channel interfaces of the isometric grid edge rasterizer.
interface igr_req_if import igr_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    func;
   logic [IDX_W-1:0]        grid_row;
   logic [IDX_W-1:0]        grid_col;
   logic signed [HGT_W-1:0] height_start;
   logic signed [HGT_W-1:0] height_end;

   modport source (output valid, func, grid_row, grid_col, height_start, height_end,
                   input ready);
   modport sink (input valid, func, grid_row, grid_col, height_start, height_end,
                 output ready);
endinterface

interface igr_rsp_if import igr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [OFF_W-1:0]   pixel_offset;
   logic [COLOR_W-1:0] write_color;
   logic               write_enable;
   logic               last_pixel;

   modport source (output valid, pixel_offset, write_color, write_enable, last_pixel,
                   input ready);
   modport sink (input valid, pixel_offset, write_color, write_enable, last_pixel,
                 output ready);
endinterface

interface igr_csr_if import igr_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ src/igr_front.sv @@
// Front end: projects an incoming edge and classifies it as level or sloped.
module igr_front import igr_pkg::*; (
   igr_req_if.sink   req_bus,
   output logic      push_vld,
   output job_type   push_job,
   input  logic      push_rdy
);

   logic [X_W-1:0]         sum_rc;
   logic signed [Y_W-1:0]  diff_cr;
   logic signed [Y_W-1:0]  h0_ext;
   logic signed [DY_W-1:0] dh;
   logic signed [DY_W-1:0] dy;
   logic                   level;

   assign sum_rc  = X_W'(req_bus.grid_row) + X_W'(req_bus.grid_col);
   assign diff_cr = $signed(Y_W'(req_bus.grid_col)) - $signed(Y_W'(req_bus.grid_row));
   assign h0_ext  = Y_W'(req_bus.height_start);
   assign dh      = DY_W'(req_bus.height_end) - DY_W'(req_bus.height_start);
   assign dy      = (dh * DY_W'(HEIGHT_DY)) +
                    (req_bus.func ? DY_W'(GRID_DY) : -DY_W'(GRID_DY));
   assign level   = (req_bus.height_start == req_bus.height_end);

   // A level edge steps seven times along x; a sloped one steps once per line of rise.
   always_comb begin
      push_job.x      = sum_rc * X_W'(GRID_DX);
      push_job.y      = (diff_cr * Y_W'(GRID_DY)) + (h0_ext * Y_W'(HEIGHT_DY));
      push_job.level  = level;
      push_job.dy_neg = dy[DY_W-1];
      if (level) begin
         push_job.len = LEN_W'(LEVEL_LEN);
         push_job.num = Q_W'(LEVEL_NUM);
      end else begin
         push_job.len = dy[DY_W-1] ? LEN_W'(-dy) : LEN_W'(dy);
         push_job.num = Q_W'(SLOPE_NUM);
      end
   end

   assign push_vld      = req_bus.valid;
   assign req_bus.ready = push_rdy;

endmodule

@@ src/igr_queue.sv @@
// Two-word queue that decouples the front end from the stepper.
module igr_queue import igr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_vld,
   input  job_type push_job,
   output logic    push_rdy,
   input  logic    pop,
   output logic    head_vld,
   output job_type head_job
);

   job_type    head_ff, head_in;
   job_type    tail_ff, tail_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push;
   logic       do_pop;

   assign push_rdy = (cnt_ff != 2'd2);
   assign head_vld = (cnt_ff != 2'd0);
   assign head_job = head_ff;
   assign do_push  = push_vld & push_rdy;
   assign do_pop   = pop & head_vld;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      cnt_in  = cnt_ff;
      case ({do_push, do_pop})
         2'b10: begin
            if (cnt_ff == 2'd0) begin
               head_in = push_job;
            end else begin
               tail_in = push_job;
            end
            cnt_in = cnt_ff + 2'd1;
         end
         2'b01: begin
            head_in = tail_ff;
            cnt_in  = cnt_ff - 2'd1;
         end
         2'b11: begin
            if (cnt_ff == 2'd1) begin
               head_in = push_job;
            end else begin
               head_in = tail_ff;
               tail_in = push_job;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

@@ src/igr_step.sv @@
// Back end stepper: walks one edge a pixel per cycle with a running remainder, unless the output stalls.
module igr_step import igr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [COORD_W-1:0] origin_x,
   input  logic [COORD_W-1:0] origin_y,
   input  logic               job_vld,
   input  job_type            job,
   output logic               job_pop,
   output logic               pix_vld,
   output pix_type            pix,
   input  logic               pix_ready
);

   logic             busy_ff, busy_in;
   job_type          job_ff, job_in;
   logic [LEN_W-1:0] m_ff, m_in;
   logic [Q_W-1:0]   q_ff, q_in;
   logic [LEN_W-1:0] r_ff, r_in;
   logic             out_vld_ff, out_vld_in;
   pix_type          out_ff, out_in;

   logic                   out_free;
   logic                   step_go;
   logic                   load;
   logic                   at_end;
   logic [LEN_W-1:0]       sx_mag;
   logic [LEN_W-1:0]       sy_mag;
   logic signed [PY_W-1:0] sy_ext;
   logic signed [PY_W-1:0] sy;
   logic [LEN_W:0]         rn;
   logic [LEN_W:0]         len2;
   logic [PX_W-1:0]        px;
   logic signed [PY_W-1:0] py;

   assign out_free = !out_vld_ff | pix_ready;
   assign step_go  = busy_ff & out_free;
   assign load     = !busy_ff & job_vld;
   assign job_pop  = load;
   assign at_end   = (m_ff == job_ff.len);

   // The step count runs on the major axis; the quotient is the minor axis.
   assign sx_mag = job_ff.level ? m_ff : LEN_W'(q_ff);
   assign sy_mag = job_ff.level ? LEN_W'(q_ff) : m_ff;
   assign sy_ext = $signed(PY_W'(sy_mag));
   assign sy     = job_ff.dy_neg ? -sy_ext : sy_ext;
   assign px     = PX_W'(origin_x) + PX_W'(job_ff.x) + PX_W'(sx_mag);
   assign py     = $signed(PY_W'(origin_y)) - PY_W'(job_ff.y) - sy;

   // The remainder stays below len; a short edge of length four can carry twice.
   assign rn   = (LEN_W + 1)'(r_ff) + (LEN_W + 1)'(job_ff.num);
   assign len2 = {job_ff.len, 1'b0};

   always_comb begin
      busy_in    = busy_ff;
      job_in     = job_ff;
      m_in       = m_ff;
      q_in       = q_ff;
      r_in       = r_ff;
      out_vld_in = out_vld_ff;
      out_in     = out_ff;
      if (out_free) begin
         out_vld_in = step_go;
      end
      if (load) begin
         busy_in = 1'b1;
         job_in  = job;
         m_in    = '0;
         q_in    = '0;
         r_in    = '0;
      end else if (step_go) begin
         out_in.px   = px;
         out_in.py   = py;
         out_in.last = at_end;
         if (at_end) begin
            busy_in = 1'b0;
         end else begin
            m_in = m_ff + LEN_W'(1);
            if (rn >= len2) begin
               q_in = q_ff + Q_W'(2);
               r_in = LEN_W'(rn - len2);
            end else if (rn >= (LEN_W + 1)'(job_ff.len)) begin
               q_in = q_ff + Q_W'(1);
               r_in = LEN_W'(rn - (LEN_W + 1)'(job_ff.len));
            end else begin
               r_in = LEN_W'(rn);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         busy_ff    <= busy_in;
         out_vld_ff <= out_vld_in;
      end
      job_ff <= job_in;
      m_ff   <= m_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
      out_ff <= out_in;
   end

   assign pix_vld = out_vld_ff;
   assign pix     = out_ff;

endmodule

@@ src/igr_pix.sv @@
// Pixel stage: clips to the canvas, forms the byte offset and drives the result word.
module igr_pix import igr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       pix_vld,
   input  pix_type    pix,
   output logic       pix_ready,
   igr_rsp_if.source  rsp_bus
);

   logic               p_vld_ff, p_vld_in;
   logic               p_en_ff, p_en_in;
   logic               p_last_ff, p_last_in;
   logic [PRODY_W-1:0] p_prody_ff, p_prody_in;
   logic [PRODX_W-1:0] p_prodx_ff, p_prodx_in;
   logic               o_vld_ff, o_vld_in;
   logic [OFF_W-1:0]   o_off_ff, o_off_in;
   logic               o_en_ff, o_en_in;
   logic               o_last_ff, o_last_in;

   logic o_rdy;
   logic p_rdy;
   logic in_canvas;

   assign o_rdy     = !o_vld_ff | rsp_bus.ready;
   assign p_rdy     = !p_vld_ff | o_rdy;
   assign pix_ready = p_rdy;

   // Column zero and line zero count as outside the canvas.
   assign in_canvas = (pix.px != '0) && (pix.px < PX_W'(cfg.canvas_width)) &&
                      !pix.py[PY_W-1] && (pix.py != '0) &&
                      (pix.py < $signed(PY_W'(cfg.canvas_height)));

   always_comb begin
      p_vld_in   = p_vld_ff;
      p_en_in    = p_en_ff;
      p_last_in  = p_last_ff;
      p_prody_in = p_prody_ff;
      p_prodx_in = p_prodx_ff;
      if (p_rdy) begin
         p_vld_in   = pix_vld;
         p_en_in    = in_canvas;
         p_last_in  = pix.last;
         p_prody_in = PRODY_W'(pix.py[COORD_W-1:0]) * PRODY_W'(cfg.row_pitch);
         p_prodx_in = PRODX_W'(pix.px[COORD_W-1:0]) * PRODX_W'(cfg.bytes_per_pixel);
      end
   end

   always_comb begin
      o_vld_in  = o_vld_ff;
      o_off_in  = o_off_ff;
      o_en_in   = o_en_ff;
      o_last_in = o_last_ff;
      if (o_rdy) begin
         o_vld_in  = p_vld_ff;
         o_en_in   = p_en_ff;
         o_last_in = p_last_ff;
         o_off_in  = p_en_ff ? (OFF_W'(p_prody_ff) + OFF_W'(p_prodx_ff)) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
         o_vld_ff <= 1'b0;
      end else begin
         p_vld_ff <= p_vld_in;
         o_vld_ff <= o_vld_in;
      end
      p_en_ff    <= p_en_in;
      p_last_ff  <= p_last_in;
      p_prody_ff <= p_prody_in;
      p_prodx_ff <= p_prodx_in;
      o_off_ff   <= o_off_in;
      o_en_ff    <= o_en_in;
      o_last_ff  <= o_last_in;
   end

   assign rsp_bus.valid        = o_vld_ff;
   assign rsp_bus.pixel_offset = o_off_ff;
   assign rsp_bus.write_color  = cfg.pixel_color;
   assign rsp_bus.write_enable = o_en_ff;
   assign rsp_bus.last_pixel   = o_last_ff;

endmodule

@@ src/isometric_grid_edge_rasterizer.sv @@
// An edge word is projected and queued by the front end, then the stepper emits one pixel
// word per cycle along the major axis unless the output stalls: an edge of equal heights
// gives 8 words, a sloped edge gives |rise| + 1 words (5 to 61), the final one flagged as
// last. The stepper loads each edge into its job register and takes no new edge until it
// has emitted the last word of it; words then pass its output register and the two pixel
// stages. A two-word queue lets new edges be taken while the stepper works, and the pixel
// pipe holds its words when the result side stalls. The register port is always ready.
module isometric_grid_edge_rasterizer import igr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   igr_req_if.sink   req_bus,
   igr_rsp_if.source rsp_bus,
   igr_csr_if.sink   csr_bus
);

   cfg_type cfg_ff, cfg_in;

   logic    push_vld;
   job_type push_job;
   logic    push_rdy;
   logic    head_vld;
   job_type head_job;
   logic    job_pop;
   logic    pix_vld;
   pix_type pix;
   logic    pix_ready;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_reg_type'(csr_bus.index))
            REG_ORIGIN_X:        cfg_in.origin_x        = csr_bus.data[COORD_W-1:0];
            REG_ORIGIN_Y:        cfg_in.origin_y        = csr_bus.data[COORD_W-1:0];
            REG_ROW_PITCH:       cfg_in.row_pitch       = csr_bus.data[PITCH_W-1:0];
            REG_BYTES_PER_PIXEL: cfg_in.bytes_per_pixel = csr_bus.data[BPP_W-1:0];
            REG_CANVAS_WIDTH:    cfg_in.canvas_width    = csr_bus.data[COORD_W-1:0];
            REG_CANVAS_HEIGHT:   cfg_in.canvas_height   = csr_bus.data[COORD_W-1:0];
            REG_PIXEL_COLOR:     cfg_in.pixel_color     = csr_bus.data[COLOR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x        <= '0;
         cfg_ff.origin_y        <= '0;
         cfg_ff.row_pitch       <= '0;
         cfg_ff.bytes_per_pixel <= BPP_W'(4);
         cfg_ff.canvas_width    <= COORD_W'(1920);
         cfg_ff.canvas_height   <= COORD_W'(1080);
         cfg_ff.pixel_color     <= COLOR_W'(32'h00FF_FFFF);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   igr_front u_front (
      .req_bus  (req_bus),
      .push_vld (push_vld),
      .push_job (push_job),
      .push_rdy (push_rdy)
   );

   igr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_vld (push_vld),
      .push_job (push_job),
      .push_rdy (push_rdy),
      .pop      (job_pop),
      .head_vld (head_vld),
      .head_job (head_job)
   );

   igr_step u_step (
      .clock     (clock),
      .reset     (reset),
      .origin_x  (cfg_ff.origin_x),
      .origin_y  (cfg_ff.origin_y),
      .job_vld   (head_vld),
      .job       (head_job),
      .job_pop   (job_pop),
      .pix_vld   (pix_vld),
      .pix       (pix),
      .pix_ready (pix_ready)
   );

   igr_pix u_pix (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pix_vld   (pix_vld),
      .pix       (pix),
      .pix_ready (pix_ready),
      .rsp_bus   (rsp_bus)
   );

endmodule
